/* rtl/assert_macros.svh */
// Concurrent assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

/* rtl/ios_pkg.sv */
package ios_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned OP_W          = 5;
  localparam int unsigned DEPTH_OUT_W   = 7;
  localparam int unsigned STATUS_W      = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNARY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BINARY = 2'd2;

  localparam logic [OP_W-1:0] UOP_PLUS = 5'd0;
  localparam logic [OP_W-1:0] UOP_NEG  = 5'd1;
  localparam logic [OP_W-1:0] UOP_INV  = 5'd2;

  localparam logic [OP_W-1:0] OP_ADD = 5'd0;
  localparam logic [OP_W-1:0] OP_SUB = 5'd1;
  localparam logic [OP_W-1:0] OP_MUL = 5'd2;
  localparam logic [OP_W-1:0] OP_DIV = 5'd3;
  localparam logic [OP_W-1:0] OP_MOD = 5'd4;
  localparam logic [OP_W-1:0] OP_AND = 5'd5;
  localparam logic [OP_W-1:0] OP_OR  = 5'd6;
  localparam logic [OP_W-1:0] OP_XOR = 5'd7;
  localparam logic [OP_W-1:0] OP_SRA = 5'd8;
  localparam logic [OP_W-1:0] OP_SLL = 5'd9;
  localparam logic [OP_W-1:0] OP_SRL = 5'd10;
  localparam logic [OP_W-1:0] OP_EQ  = 5'd11;
  localparam logic [OP_W-1:0] OP_NE  = 5'd12;
  localparam logic [OP_W-1:0] OP_LE  = 5'd13;
  localparam logic [OP_W-1:0] OP_GE  = 5'd14;
  localparam logic [OP_W-1:0] OP_LT  = 5'd15;
  localparam logic [OP_W-1:0] OP_GT  = 5'd16;
  localparam logic [OP_W-1:0] OP_LAND = 5'd17;
  localparam logic [OP_W-1:0] OP_LOR  = 5'd18;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADOP = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [OP_W-1:0]          op_code;
    logic signed [DATA_W-1:0] push_value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_OUT_W-1:0]   stack_depth;
    logic [STATUS_W-1:0]      status;
  } result_t;

  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] op;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

/* rtl/ios_stack.sv */
module ios_stack import ios_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/ios_alu.sv */
module ios_alu import ios_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  alu_ctl_t          ctl,
  input  logic [DATA_W-1:0] lhs,
  input  logic [DATA_W-1:0] rhs,
  output alu_stat_t         stat,
  output logic [DATA_W-1:0] result
);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_MUL  = 2'd1;
  localparam logic [1:0] A_DIV  = 2'd2;
  localparam logic [1:0] A_FIX  = 2'd3;
  localparam int unsigned CNT_W = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  logic [1:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] aux;
  logic [DATA_W-1:0] opnd;
  logic              is_mul;
  logic              is_mod;
  logic              neg_res;
  logic              done;

  logic [4:0]        sh;
  logic [DATA_W-1:0] simple;
  logic [DATA_W-1:0] lhs_mag;
  logic [DATA_W-1:0] rhs_mag;
  logic [DATA_W-1:0] shifted;
  logic [DATA_W:0]   trial;

  assign sh      = rhs[4:0];
  assign lhs_mag = lhs[DATA_W-1] ? (~lhs + 1'b1) : lhs;
  assign rhs_mag = rhs[DATA_W-1] ? (~rhs + 1'b1) : rhs;
  assign shifted = {acc[DATA_W-2:0], aux[DATA_W-1]};
  assign trial   = {1'b0, shifted} - {1'b0, opnd};

  always_comb begin
    unique case (ctl.op)
      OP_ADD:  simple = lhs + rhs;
      OP_SUB:  simple = lhs - rhs;
      OP_AND:  simple = lhs & rhs;
      OP_OR:   simple = lhs | rhs;
      OP_XOR:  simple = lhs ^ rhs;
      OP_SRA:  simple = DATA_W'($signed(lhs) >>> sh);
      OP_SLL:  simple = lhs << sh;
      OP_SRL:  simple = lhs >> sh;
      OP_EQ:   simple = DATA_W'(lhs == rhs);
      OP_NE:   simple = DATA_W'(lhs != rhs);
      OP_LE:   simple = DATA_W'($signed(lhs) <= $signed(rhs));
      OP_GE:   simple = DATA_W'($signed(lhs) >= $signed(rhs));
      OP_LT:   simple = DATA_W'($signed(lhs) < $signed(rhs));
      OP_GT:   simple = DATA_W'($signed(lhs) > $signed(rhs));
      OP_LAND: simple = DATA_W'((lhs != '0) && (rhs != '0));
      OP_LOR:  simple = DATA_W'((lhs != '0) || (rhs != '0));
      default: simple = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (ctl.start) begin
            cnt <= '0;
            acc <= '0;
            if (ctl.op == OP_MUL) begin
              aux    <= rhs;
              opnd   <= lhs;
              is_mul <= 1'b1;
              state  <= A_MUL;
            end else if ((ctl.op == OP_DIV || ctl.op == OP_MOD) && rhs != '0) begin
              aux     <= lhs_mag;
              opnd    <= rhs_mag;
              is_mul  <= 1'b0;
              is_mod  <= (ctl.op == OP_MOD);
              neg_res <= (ctl.op == OP_MOD) ? lhs[DATA_W-1]
                                            : (lhs[DATA_W-1] ^ rhs[DATA_W-1]);
              state   <= A_DIV;
            end else begin
              result <= simple;
              done   <= 1'b1;
            end
          end
        end
        A_MUL: begin
          if (aux[0]) begin
            acc <= acc + opnd;
          end
          opnd <= opnd << 1;
          aux  <= aux >> 1;
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= A_FIX;
          end
        end
        A_DIV: begin
          acc <= trial[DATA_W] ? shifted : trial[DATA_W-1:0];
          aux <= {aux[DATA_W-2:0], ~trial[DATA_W]};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          if (is_mul) begin
            result <= acc;
          end else if (is_mod) begin
            result <= neg_res ? (~acc + 1'b1) : acc;
          end else begin
            result <= neg_res ? (~aux + 1'b1) : aux;
          end
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != A_IDLE);
  assign stat.done = done;

endmodule

/* rtl/integer_operand_stack_alu.sv */
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_ready    item_t   (cmd, op_code, push_value)
// result    out        result_valid / result_ready result_t (top_value, stack_depth, status)
//
// Push, unary plus, errors and unused commands go straight to done; unary drop
// first loads the new top; an unknown binary code drops two entries, then fetches
// and loads the new top; other ops wait in execute for the shared ALU, whose 32
// one-bit steps serve multiply and nonzero divide or modulo. item_ready is high only while idle.
// Reset empties the stack at once; the operand memory is not cleared.
// A word waiting in the result register holds the next item at its last step.
`include "assert_macros.svh"

module integer_operand_stack_alu import ios_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned SW = $clog2(STACK_DEPTH + 1);
  localparam logic [SW-1:0] SP_FULL = SW'(STACK_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOADL = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_TOSLD = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]          state;
  logic [SW-1:0]       sp;
  logic [DATA_W-1:0]   tos;
  logic [STATUS_W-1:0] status;
  logic                is_bin;
  logic [OP_W-1:0]     op_q;

  logic                accept;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic [AW-1:0]       rd_addr;
  logic [DATA_W-1:0]   rd_data;

  alu_ctl_t            alu_ctl;
  alu_stat_t           alu_stat;
  logic [DATA_W-1:0]   alu_l;
  logic [DATA_W-1:0]   alu_r;
  logic [DATA_W-1:0]   alu_res;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;

  ios_stack #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ios_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (alu_ctl),
    .lhs    (alu_l),
    .rhs    (alu_r),
    .stat   (alu_stat),
    .result (alu_res)
  );

  // second entry while idle, new top once two entries are dropped
  assign rd_addr = (state == S_FETCH) ? AW'(sp - SW'(1)) : AW'(sp - SW'(2));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(sp);
    wr_data = item.push_value;
    if (accept && item.cmd == CMD_PUSH && sp != SP_FULL) begin
      wr_en = 1'b1;
    end else if (state == S_EXEC && alu_stat.done) begin
      wr_en   = 1'b1;
      wr_addr = is_bin ? AW'(sp - SW'(2)) : AW'(sp - SW'(1));
      wr_data = alu_res;
    end
  end

  always_comb begin
    alu_ctl.start = 1'b0;
    alu_ctl.op    = OP_ADD;
    alu_l         = tos;
    alu_r         = tos;
    if (accept && item.cmd == CMD_UNARY && sp != '0
        && (item.op_code == UOP_NEG || item.op_code == UOP_INV)) begin
      alu_ctl.start = 1'b1;
      if (item.op_code == UOP_NEG) begin
        alu_ctl.op = OP_SUB;
        alu_l      = '0;
      end else begin
        alu_ctl.op = OP_XOR;
        alu_r      = '1;
      end
    end else if (state == S_LOADL && op_q <= OP_LOR) begin
      alu_ctl.start = 1'b1;
      alu_ctl.op    = op_q;
      alu_l         = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sp           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            status <= ST_OK;
            is_bin <= (item.cmd == CMD_BINARY);
            op_q   <= item.op_code;
            state  <= S_DONE;
            unique case (item.cmd)
              CMD_PUSH: begin
                if (sp == SP_FULL) begin
                  status <= ST_OVER;
                end else begin
                  sp  <= sp + SW'(1);
                  tos <= item.push_value;
                end
              end
              CMD_UNARY: begin
                if (sp == '0) begin
                  status <= ST_UNDER;
                end else if (item.op_code == UOP_NEG || item.op_code == UOP_INV) begin
                  state <= S_EXEC;
                end else if (item.op_code != UOP_PLUS) begin
                  sp    <= sp - SW'(1);
                  state <= S_TOSLD;
                end
              end
              CMD_BINARY: begin
                if (sp < SW'(2)) begin
                  status <= ST_UNDER;
                end else begin
                  state <= S_LOADL;
                end
              end
              default: ;
            endcase
          end
        end
        S_LOADL: begin
          if (op_q <= OP_LOR) begin
            state <= S_EXEC;
          end else begin
            sp     <= sp - SW'(2);
            status <= ST_BADOP;
            state  <= S_FETCH;
          end
        end
        S_FETCH: state <= S_TOSLD;
        S_TOSLD: begin
          tos   <= rd_data;
          state <= S_DONE;
        end
        S_EXEC: begin
          if (alu_stat.done) begin
            tos <= alu_res;
            if (is_bin) begin
              sp <= sp - SW'(1);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid       <= 1'b1;
            result.top_value   <= (sp != '0) ? tos : '0;
            result.stack_depth <= DEPTH_OUT_W'(sp);
            result.status      <= status;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_push_grows, clk, rst, accept && item.cmd == CMD_PUSH && sp != SP_FULL |=> sp == $past(sp) + SW'(1), "push did not grow the stack")
  `ASSERT_CLK(a_sp_bound, clk, rst, sp <= SP_FULL, "stack pointer beyond depth")
  `ASSERT_CLK(a_alu_start_idle, clk, rst, alu_ctl.start |-> !alu_stat.busy && state != S_EXEC, "ALU started while busy")
  `ASSERT_NORST(a_reset_clears, clk, rst |=> sp == '0 && !result_valid && item_ready, "reset left state behind")

endmodule
